// File: rtl/sss_pkg.sv
// Shared types, constants and the digit select table for the seven-segment scan serializer.
package sss_pkg;

	localparam int DIGITS_DEFAULT = 8;
	localparam int BYTE_W         = 8;
	localparam int BITS_PER_TICK  = 24;
	localparam int BIT_CNT_W      = 5;
	localparam int LEN_W          = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [LEN_W-1:0]  SCAN_LENGTH_RST  = 4'd7;
	localparam logic [BYTE_W-1:0] BLANK_SELECT_RST = 8'hf0;
	localparam logic [BYTE_W-1:0] SEG_LOW_RST      = 8'h00;
	localparam logic [BYTE_W-1:0] SEG_HIGH_RST     = 8'hff;
	localparam int                SEG_LOW_COUNT    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SCAN_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_SELECT = 1'd1;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic CHAIN_SELECT  = 1'b0;
	localparam logic CHAIN_SEGMENT = 1'b1;

	// Bytes of one scan tick, in the order they are shifted out.
	typedef struct packed {
		logic [BYTE_W-1:0] blank;
		logic [BYTE_W-1:0] segment;
		logic [BYTE_W-1:0] select;
	} frame_t;

	function automatic logic [BYTE_W-1:0] select_code(input logic [2:0] idx);
		logic [BYTE_W-1:0] code;
		case (idx)
			3'd0: code = 8'h70;
			3'd1: code = 8'hb0;
			3'd2: code = 8'hd0;
			3'd3: code = 8'he0;
			3'd4: code = 8'hf8;
			3'd5: code = 8'hf4;
			3'd6: code = 8'hf2;
			3'd7: code = 8'hf0;
			default: code = 8'hf0;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/seven_segment_scan_serializer_top.sv
// Top level of the seven-segment scan serializer: front end, frame queue and serializer.
//
// This block drives a multiplexed seven-segment display through two serial shift-register
// chains. A write item (command 1) stores segment_byte at buffer position and produces no
// output; positions at or beyond DIGITS are ignored. A scan tick (command 0) produces 24
// output transfers, one serial bit each, most significant bit first: the blank_select byte
// on the select chain, then the current digit's buffered segment byte on the segment chain,
// then that digit's fixed select code on the select chain. The latch flag marks the eighth
// bit of every byte and last marks the 24th bit. After each tick the scan index advances
// and wraps to zero at the scan length (0 counts as 1, values above DIGITS count as DIGITS).
// Throughput is one output bit per cycle while out_ready is high; consecutive ticks stream
// without a gap. The front end captures a tick's three bytes in a two-entry queue at the
// moment the input transfer happens, so it accepts input in the very cycle it arrives as
// long as the queue has room, and a write that follows a tick never alters that tick's
// bits. Writes also wait while the queue is full.
// Configuration writes take effect at once and are meant for idle periods only.
module seven_segment_scan_serializer_top #(
	parameter int DIGITS = sss_pkg::DIGITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [2:0]                     position,
	input  logic [7:0]                     segment_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           chain,
	output logic                           data_bit,
	output logic                           latch,
	output logic                           last
);
	import sss_pkg::*;

	// Frames travel from the front end to the serializer through the queue.
	logic   push_valid;
	logic   push_ready;
	frame_t push_frame;
	logic   pop_valid;
	logic   pop_ready;
	frame_t pop_frame;

	sss_front #(
		.DIGITS(DIGITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.position    (position),
		.segment_byte(segment_byte),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_frame  (push_frame)
	);

	sss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_frame(push_frame),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_frame (pop_frame)
	);

	// The serializer holds its output bit steady until the transfer completes.
	sss_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_frame(pop_frame),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chain    (chain),
		.data_bit (data_bit),
		.latch    (latch),
		.last     (last)
	);

endmodule

// File: rtl/sss_front.sv
// Front end: takes items, holds the segment buffer, scan index and registers, builds tick frames.
module sss_front #(
	parameter int DIGITS = sss_pkg::DIGITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [2:0]                     position,
	input  logic [7:0]                     segment_byte,
	output logic                           push_valid,
	input  logic                           push_ready,
	output sss_pkg::frame_t                push_frame
);
	import sss_pkg::*;

	localparam int IDX_W = $clog2(DIGITS);

	logic [BYTE_W-1:0] seg_buf_q [DIGITS];
	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  scan_length_q;
	logic [BYTE_W-1:0] blank_select_q;

	logic              accept;
	logic              wr_hit;
	logic [LEN_W-1:0]  len_eff;
	logic [LEN_W-1:0]  idx_inc;
	logic [IDX_W-1:0]  idx_next;

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && (command == CMD_TICK);

	assign push_frame.blank   = blank_select_q;
	assign push_frame.segment = seg_buf_q[idx_q];
	assign push_frame.select  = select_code(3'(idx_q));

	assign wr_hit = ({1'b0, position} < LEN_W'(DIGITS));

	always_comb begin
		if (scan_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (scan_length_q > LEN_W'(DIGITS)) begin
			len_eff = LEN_W'(DIGITS);
		end else begin
			len_eff = scan_length_q;
		end
		idx_inc = LEN_W'(idx_q) + LEN_W'(1);
		if (idx_inc >= len_eff) begin
			idx_next = '0;
		end else begin
			idx_next = idx_inc[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				seg_buf_q[i] <= (i < SEG_LOW_COUNT) ? SEG_LOW_RST : SEG_HIGH_RST;
			end
			idx_q          <= '0;
			scan_length_q  <= SCAN_LENGTH_RST;
			blank_select_q <= BLANK_SELECT_RST;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SCAN_LENGTH:  scan_length_q  <= cfg_wdata[LEN_W-1:0];
					REG_BLANK_SELECT: blank_select_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				if (command == CMD_WRITE) begin
					if (wr_hit) begin
						seg_buf_q[position[IDX_W-1:0]] <= segment_byte;
					end
				end else begin
					idx_q <= idx_next;
				end
			end
		end
	end

endmodule

// File: rtl/sss_queue.sv
// Short frame queue between the front end and the serializer.
module sss_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sss_pkg::frame_t push_frame,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sss_pkg::frame_t pop_frame
);
	import sss_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_frame  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/sss_back.sv
// Serializer: shifts each queued frame out as 24 bits with chain, latch and last flags.
module sss_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  sss_pkg::frame_t pop_frame,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            chain,
	output logic            data_bit,
	output logic            latch,
	output logic            last
);
	import sss_pkg::*;

	logic [BITS_PER_TICK-1:0] shift_q;
	logic [BIT_CNT_W-1:0]     count_q;
	logic                     busy_q;
	logic                     out_xfer;
	logic                     at_last;
	logic                     load;

	assign at_last   = (count_q == BIT_CNT_W'(BITS_PER_TICK - 1));
	assign out_xfer  = busy_q && out_ready;
	assign pop_ready = !busy_q || (out_xfer && at_last);
	assign load      = pop_valid && pop_ready;

	assign out_valid = busy_q;
	assign data_bit  = shift_q[BITS_PER_TICK-1];
	assign latch     = (count_q[2:0] == 3'd7);
	assign last      = at_last;
	// Bits 8 to 15 of a tick belong to the segment byte.
	assign chain     = (count_q[BIT_CNT_W-1:3] == 2'd1) ? CHAIN_SEGMENT : CHAIN_SELECT;

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= pop_frame;
		end else if (out_xfer) begin
			shift_q <= {shift_q[BITS_PER_TICK-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (out_xfer) begin
				if (at_last) begin
					busy_q  <= 1'b0;
					count_q <= '0;
				end else begin
					count_q <= count_q + BIT_CNT_W'(1);
				end
			end
		end
	end

endmodule

// File: rtl/sss_checker.sv
// Port-level checks for the seven-segment scan serializer, bound to the top level.
module sss_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic chain,
	input logic data_bit,
	input logic latch,
	input logic last
);

	// A stalled output bit keeps its value and flags.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chain) && $stable(data_bit)
			&& $stable(latch) && $stable(last))
		else $error("output changed while stalled");

	// The final bit of a tick closes a byte on the select chain.
	a_last_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> latch && !chain)
		else $error("last bit without latch or on segment chain");

	// Bits within a byte stream without a gap.
	a_byte_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !latch |=> out_valid)
		else $error("gap inside a byte");

	// After the segment byte is latched the select code follows at once.
	a_seg_then_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && latch && chain |=> out_valid && !chain && !last)
		else $error("select code did not follow segment byte");

endmodule

bind seven_segment_scan_serializer_top sss_checker u_sss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.chain    (chain),
	.data_bit (data_bit),
	.latch    (latch),
	.last     (last)
);
